### hw/rtl/priority_queue_fifo_ties_core_macros.svh
// Assertion helpers for the priority queue core.
`ifndef PRIORITY_QUEUE_FIFO_TIES_CORE_MACROS_SVH
`define PRIORITY_QUEUE_FIFO_TIES_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PQFT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqft assertion failed");
// Next-cycle implication.
`define PQFT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqft assertion failed");
`else
`define PQFT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define PQFT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/pqft_pkg.sv
`default_nettype none

package pqft_pkg;

   localparam int CAPACITY      = 16;
   localparam int VALUE_BITS    = 32;
   localparam int PRIORITY_BITS = 4;
   localparam int LIMIT_BITS    = 5;
   localparam int IDX_BITS      = $clog2(CAPACITY);
   localparam int CNT_BITS      = $clog2(CAPACITY + 1);

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);

   // Stream payload sizes
   localparam int REQ_USED_BITS = PRIORITY_BITS + VALUE_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;
   localparam int RSP_USED_BITS = 2 + VALUE_BITS + PRIORITY_BITS + CNT_BITS + 1 + VALUE_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;

   // CSR map
   localparam int CSR_ADDR_BITS = 3;
   localparam logic REG_PRIORITY_LIMIT = 1'b0;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_BAD_PRIO = 2'd3
   } status_type;

   // Command to the front tracker
   typedef struct packed {
      logic load;   // offer a candidate this cycle
      logic first;  // candidate wins unconditionally
   } front_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/pqft_front.sv
`default_nettype none

// Front tracker: one shared less-than compare, used for pushes and for
// the rescan after a pop. Strict compare keeps the oldest on ties.
module pqft_front (
   input  wire logic                                 clock,
   input  wire pqft_pkg::front_cmd_type              cmd,
   input  wire logic [pqft_pkg::IDX_BITS-1:0]        cand_idx,
   input  wire logic [pqft_pkg::PRIORITY_BITS-1:0]   cand_prio,
   output logic      [pqft_pkg::IDX_BITS-1:0]        front_idx,
   output logic      [pqft_pkg::PRIORITY_BITS-1:0]   front_prio
);

   logic [pqft_pkg::IDX_BITS-1:0]      best_idx_ff;
   logic [pqft_pkg::PRIORITY_BITS-1:0] best_prio_ff;
   logic                               take;

   assign take = cmd.first || (cand_prio < best_prio_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && take) begin
         best_idx_ff  <= cand_idx;
         best_prio_ff <= cand_prio;
      end
   end

   assign front_idx  = best_idx_ff;
   assign front_prio = best_prio_ff;

endmodule

`default_nettype wire

### hw/rtl/priority_queue_fifo_ties_core.sv
`default_nettype none

// Stable bounded priority queue, 16 entries.
// req channel: one transaction per operation. req_tuser is the mode (push or
// pop); req_tdata carries the pushed priority and value.
// rsp channel: exactly one transaction per request: status, removed entry,
// count held afterwards and the value that the next pop would return.
// csr port: APB-style, register 0 (byte address 0) is priority_limit; pushes
// with priority >= limit are refused. Write it only while the core is idle.
// Timing: a request is taken in IDLE. A push, a refused op or a pop that
// empties the queue goes from EXEC straight to DONE. A pop that leaves
// entries behind reruns the front search in SCAN with the single compare
// unit, one held entry per cycle, then goes to DONE. req_tready is low from
// acceptance until the result is loaded into the output register, so the
// next request can be taken in the cycle after that load at the earliest.
// A stalled rsp_tready holds the result in the output register; the core
// returns to IDLE and takes the next request, but cannot hand over a new
// result until the old one is taken.
// Reset: queue empty, priority_limit = 16, no result pending.
module priority_queue_fifo_ties_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request stream
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [pqft_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // priority_req, value
   input  wire logic                                   req_tuser,  // mode
   // response stream
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // status, removed_value, removed_priority, count, front_valid, front_value
   output logic      [pqft_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // CSR port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [pqft_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [31:0]                            csr_pwdata,
   output logic      [31:0]                            csr_prdata,
   output logic                                        csr_pready
);

`include "priority_queue_fifo_ties_core_macros.svh"

   localparam int VB = pqft_pkg::VALUE_BITS;
   localparam int PB = pqft_pkg::PRIORITY_BITS;
   localparam int IB = pqft_pkg::IDX_BITS;
   localparam int CB = pqft_pkg::CNT_BITS;
   localparam int LB = pqft_pkg::LIMIT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [CB-1:0]             count_ff;
   logic [LB-1:0]             limit_ff;
   logic [IB-1:0]             scan_idx_ff;

   // latched request
   logic                      op_mode_ff;
   logic [PB-1:0]             op_prio_ff;
   logic [VB-1:0]             op_value_ff;

   // result under construction
   pqft_pkg::status_type      status_ff;
   logic [VB-1:0]             rem_value_ff;
   logic [PB-1:0]             rem_prio_ff;

   // output register
   logic                      rsp_valid_ff;
   pqft_pkg::status_type      out_status_ff;
   logic [VB-1:0]             out_rem_value_ff;
   logic [PB-1:0]             out_rem_prio_ff;
   logic [CB-1:0]             out_count_ff;
   logic                      out_front_valid_ff;
   logic [VB-1:0]             out_front_value_ff;

   // entry store, arrival order, no reset (slots above count never read)
   logic [VB-1:0]             values_ff [pqft_pkg::CAPACITY];
   logic [PB-1:0]             prios_ff  [pqft_pkg::CAPACITY];

   logic                      accept;
   logic                      push_ok;
   logic                      pop_ok;
   logic                      out_free;
   logic                      scan_last;
   logic [CB-1:0]             count_dec;
   logic [IB-1:0]             front_idx;
   logic [PB-1:0]             front_prio;
   logic [VB-1:0]             front_value;
   pqft_pkg::front_cmd_type   front_cmd;
   logic [IB-1:0]             cand_idx;
   logic [PB-1:0]             cand_prio;
   logic                      csr_write;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign count_dec = CB'(count_ff - 1'b1);
   assign scan_last = ({1'b0, scan_idx_ff} == count_dec);

   // push goes in when priority is legal and there is room
   assign push_ok = (op_mode_ff == pqft_pkg::MODE_PUSH)
                    && ({1'b0, op_prio_ff} < limit_ff)
                    && (count_ff < CB'(pqft_pkg::CAPACITY));
   assign pop_ok  = (op_mode_ff == pqft_pkg::MODE_POP) && (count_ff != '0);

   assign front_value = values_ff[front_idx];

   // shared compare unit: pushed entry in EXEC, stored entries in SCAN
   always_comb begin
      front_cmd = '0;
      cand_idx  = scan_idx_ff;
      cand_prio = prios_ff[scan_idx_ff];
      if (state_ff == ST_EXEC) begin
         front_cmd.load  = push_ok;
         front_cmd.first = (count_ff == '0);
         cand_idx        = count_ff[IB-1:0];
         cand_prio       = op_prio_ff;
      end else if (state_ff == ST_SCAN) begin
         front_cmd.load  = 1'b1;
         front_cmd.first = (scan_idx_ff == '0);
      end
   end

   pqft_front u_front (
      .clock      (clock),
      .cmd        (front_cmd),
      .cand_idx   (cand_idx),
      .cand_prio  (cand_prio),
      .front_idx  (front_idx),
      .front_prio (front_prio)
   );

   // entry store: append on push, close the gap on pop
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         if (push_ok) begin
            values_ff[count_ff[IB-1:0]] <= op_value_ff;
            prios_ff[count_ff[IB-1:0]]  <= op_prio_ff;
         end else if (pop_ok) begin
            for (int i = 0; i < pqft_pkg::CAPACITY - 1; i++) begin
               if (IB'(i) >= front_idx) begin
                  values_ff[i] <= values_ff[i+1];
                  prios_ff[i]  <= prios_ff[i+1];
               end
            end
         end
      end
   end

   // CSR
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == pqft_pkg::REG_PRIORITY_LIMIT)
                       ? {{(32-LB){1'b0}}, limit_ff} : 32'd0;

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= pqft_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == pqft_pkg::REG_PRIORITY_LIMIT)) begin
            limit_ff <= csr_pwdata[LB-1:0];
         end
         // DONE reloads the output register itself when it is taken
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_mode_ff  <= req_tuser;
                  op_prio_ff  <= req_tdata[PB-1:0];
                  op_value_ff <= req_tdata[PB+VB-1:PB];
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (op_mode_ff == pqft_pkg::MODE_PUSH) begin
                  rem_value_ff <= '0;
                  rem_prio_ff  <= '0;
                  state_ff     <= ST_DONE;
                  if ({1'b0, op_prio_ff} >= limit_ff) begin
                     status_ff <= pqft_pkg::STATUS_BAD_PRIO;
                  end else if (!push_ok) begin
                     status_ff <= pqft_pkg::STATUS_FULL;
                  end else begin
                     status_ff <= pqft_pkg::STATUS_OK;
                     count_ff  <= CB'(count_ff + 1'b1);
                  end
               end else if (!pop_ok) begin
                  status_ff    <= pqft_pkg::STATUS_EMPTY;
                  rem_value_ff <= '0;
                  rem_prio_ff  <= '0;
                  state_ff     <= ST_DONE;
               end else begin
                  status_ff    <= pqft_pkg::STATUS_OK;
                  rem_value_ff <= front_value;
                  rem_prio_ff  <= front_prio;
                  count_ff     <= count_dec;
                  scan_idx_ff  <= '0;
                  if (count_dec != '0) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_SCAN: begin
               if (scan_last) begin
                  state_ff <= ST_DONE;
               end else begin
                  scan_idx_ff <= IB'(scan_idx_ff + 1'b1);
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  out_status_ff      <= status_ff;
                  out_rem_value_ff   <= rem_value_ff;
                  out_rem_prio_ff    <= rem_prio_ff;
                  out_count_ff       <= count_ff;
                  out_front_valid_ff <= (count_ff != '0);
                  out_front_value_ff <= (count_ff != '0) ? front_value : '0;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pqft_pkg::RSP_DATA_BITS - pqft_pkg::RSP_USED_BITS){1'b0}},
                        out_front_value_ff, out_front_valid_ff, out_count_ff,
                        out_rem_prio_ff, out_rem_value_ff, out_status_ff};

   `PQFT_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `PQFT_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1,
      count_ff <= CB'(pqft_pkg::CAPACITY))
   `PQFT_ASSERT_IMPLIES(a_scan_in_range, clock, reset, state_ff == ST_SCAN,
      CB'(scan_idx_ff) < count_ff)
   `PQFT_ASSERT_IMPLIES(a_front_valid_matches, clock, reset, rsp_valid_ff,
      out_front_valid_ff == (out_count_ff != '0))

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // No-progress limit. The longest quiet stretch in a correct run is the
   // forced output stall plus one pop scan.
   localparam int WATCHDOG_CYCLES = 4000;
   // Settle time after the last result: longer than the scan after a pop from a full queue.
   localparam int SETTLE_CYCLES   = 24;
   localparam int MAX_REPORTS     = 10;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_OPS       = 110;

   localparam int VB  = pqft_pkg::VALUE_BITS;
   localparam int PB  = pqft_pkg::PRIORITY_BITS;
   localparam int CB  = pqft_pkg::CNT_BITS;
   localparam int LB  = pqft_pkg::LIMIT_BITS;
   localparam int AB  = pqft_pkg::CSR_ADDR_BITS;
   localparam int QDB = pqft_pkg::REQ_DATA_BITS;
   localparam int SDB = pqft_pkg::RSP_DATA_BITS;
   localparam int SUB = pqft_pkg::RSP_USED_BITS;

   localparam logic [AB-1:0] LIMIT_ADDR =
      AB'(4 * int'(pqft_pkg::REG_PRIORITY_LIMIT));

   // rsp_tdata layout, lowest bits last in this list
   typedef struct packed {
      logic [SDB-SUB-1:0]   pad;
      logic [VB-1:0]        front_value;
      logic                 front_valid;
      logic [CB-1:0]        count;
      logic [PB-1:0]        removed_priority;
      logic [VB-1:0]        removed_value;
      pqft_pkg::status_type status;
   } pq_result_type;

   // how the result side accepts transactions
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN,
      RX_SLOW
   } rx_style_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;

   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [QDB-1:0]               req_tdata = '0;   // priority_req, value
   logic                         req_tuser = 1'b0; // mode

   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   // status, removed_value, removed_priority, count, front_valid, front_value
   logic [SDB-1:0]               rsp_tdata;

   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [AB-1:0]                csr_paddr = '0;
   logic [31:0]                  csr_pwdata = '0;
   logic [31:0]                  csr_prdata;
   logic                         csr_pready;

   // Shadow of the queue: entries in arrival order, plus the limit register.
   logic [VB-1:0]                held_value[$];
   logic [PB-1:0]                held_prio[$];
   logic [LB-1:0]                limit_shadow = pqft_pkg::LIMIT_RESET;

   // Results predicted at request acceptance, oldest first.
   pq_result_type                pending_results[$];

   int                           ops_sent = 0;
   int                           results_seen = 0;
   int                           fail_count = 0;
   int                           limit_writes = 0;
   int                           status_seen[4] = '{0, 0, 0, 0};
   int                           idle_cycles = 0;

   // sender burst state
   int                           burst_left = 0;
   bit                           gapless = 1'b0;

   // receiver state
   rx_style_type                 rx_style = RX_ALWAYS;
   int                           rx_tick = 0;
   int                           hold_left = 0;
   bit                           hold_start = 1'b0;

   priority_queue_fifo_ties_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow queue
   // ---------------------------------------------------------------

   // Oldest entry among those with the smallest priority number.
   // Strict less-than keeps the earlier slot on a tie.
   function automatic int urgent_slot();
      int best = 0;
      for (int i = 1; i < held_prio.size(); i++) begin
         if (held_prio[i] < held_prio[best]) best = i;
      end
      return best;
   endfunction

   // Applies one transaction to the shadow queue and returns the result
   // the core must produce for it.
   function automatic pq_result_type apply_op(input logic op,
                                              input logic [PB-1:0] prio,
                                              input logic [VB-1:0] val);
      pq_result_type r;
      int k;
      r = '0;
      r.status = pqft_pkg::STATUS_OK;
      if (op == pqft_pkg::MODE_PUSH) begin
         // priority check wins over the full check
         if (prio >= limit_shadow) begin
            r.status = pqft_pkg::STATUS_BAD_PRIO;
         end else if (held_value.size() >= pqft_pkg::CAPACITY) begin
            r.status = pqft_pkg::STATUS_FULL;
         end else begin
            held_value.push_back(val);
            held_prio.push_back(prio);
         end
      end else if (held_value.size() == 0) begin
         r.status = pqft_pkg::STATUS_EMPTY;
      end else begin
         // pop ignores the current limit: entries held from before stay eligible
         k = urgent_slot();
         r.removed_value = held_value[k];
         r.removed_priority = held_prio[k];
         held_value.delete(k);
         held_prio.delete(k);
      end
      r.count = CB'(held_value.size());
      if (held_value.size() > 0) begin
         r.front_valid = 1'b1;
         r.front_value = held_value[urgent_slot()];
      end
      return r;
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   // ---------------------------------------------------------------
   // Monitors: request acceptance feeds the shadow, results are checked
   // against the oldest prediction. All sampling at the rising edge.
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pending_results.push_back(apply_op(req_tuser, req_tdata[PB-1:0],
                                            req_tdata[PB +: VB]));
      end
   end

   always @(posedge clock) begin : rsp_check
      pq_result_type got;
      pq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = pq_result_type'(rsp_tdata);
         results_seen++;
         if (pending_results.size() == 0) begin
            report_failure($sformatf("result transaction with nothing expected: %h",
                                     rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status ||
                got.removed_value !== want.removed_value ||
                got.removed_priority !== want.removed_priority ||
                got.count !== want.count ||
                got.front_valid !== want.front_valid ||
                got.front_value !== want.front_value) begin
               report_failure($sformatf(
                  {"result %0d: expected st=%0d rv=%h rp=%0d cnt=%0d fv=%0b fval=%h,",
                   " got st=%0d rv=%h rp=%0d cnt=%0d fv=%0b fval=%h"},
                  results_seen, want.status, want.removed_value, want.removed_priority,
                  want.count, want.front_valid, want.front_value,
                  got.status, got.removed_value, got.removed_priority,
                  got.count, got.front_valid, got.front_value));
            end
         end
      end
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog: no transaction for %0d cycles, %0d of %0d results seen",
                  idle_cycles, results_seen, ops_sent);
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: its own stall pattern, overridden by a long hold-off on request.
   always @(negedge clock) begin
      rx_tick++;
      if (hold_start) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_style)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_tready <= ((rx_tick % 9) > 2);
            default:    rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Drivers: inputs change at the falling edge only
   // ---------------------------------------------------------------

   // Offers one request and returns at the edge where it is taken.
   // tvalid stays high; the caller or the pause logic drops it.
   task automatic issue_op(input logic op, input logic [PB-1:0] prio,
                           input logic [VB-1:0] val);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= QDB'({val, prio});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ops_sent++;
   endtask

   // Burst/gap pacing between requests.
   task automatic sender_pause();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = gapless ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Waits until every request has its result, then lets the core settle.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_seen < ops_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access cycle.
   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (write) limit_shadow = wdata[LB-1:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_priority_limit();
      logic [31:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== 32'(limit_shadow)) begin
         report_failure($sformatf("priority_limit read %h, expected %h", rd, limit_shadow));
      end
   endtask

   // Drains all results first, so the write lands with the core idle.
   task automatic set_priority_limit(input logic [LB-1:0] limit);
      logic [31:0] rd;
      drain_results();
      csr_access(1'b1, 32'(limit), rd);
      limit_writes++;
      check_priority_limit();
   endtask

   function automatic logic [VB-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Random push/pop steered toward a fill level, mostly legal priorities,
   // with ties near the front and some out-of-range pushes.
   task automatic random_op(input int fill_target);
      int top;
      int roll;
      logic op;
      logic [PB-1:0] prio;
      top = (limit_shadow > 16) ? 16 : int'(limit_shadow);
      if (held_value.size() < fill_target) begin
         op = ($urandom_range(0, 9) < 8) ? pqft_pkg::MODE_PUSH : pqft_pkg::MODE_POP;
      end else begin
         op = ($urandom_range(0, 9) < 2) ? pqft_pkg::MODE_PUSH : pqft_pkg::MODE_POP;
      end
      roll = $urandom_range(0, 9);
      if (top == 0) begin
         prio = PB'($urandom_range(0, 15));
      end else if (top < 16 && roll == 0) begin
         prio = PB'($urandom_range(top, 15));
      end else if (roll < 4) begin
         prio = PB'($urandom_range(0, (top > 3) ? 2 : top - 1));
      end else begin
         prio = PB'($urandom_range(0, top - 1));
      end
      issue_op(op, prio, pick_value());
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Limit comes up at 16; a pop on the fresh queue reports empty.
   task automatic test_reset_state();
      check_priority_limit();
      issue_op(pqft_pkg::MODE_POP, '1, '1);
   endtask

   // Priority and value extremes, and oldest-first among equal priorities.
   task automatic test_extremes_and_ties();
      issue_op(pqft_pkg::MODE_PUSH, 4'd15, 32'h7fff_ffff);
      issue_op(pqft_pkg::MODE_PUSH, 4'd0, 32'h8000_0000);
      issue_op(pqft_pkg::MODE_PUSH, 4'd0, 32'hffff_ffff);
      issue_op(pqft_pkg::MODE_PUSH, 4'd5, 32'h0000_0000);
      issue_op(pqft_pkg::MODE_POP, 4'd0, '0);
      issue_op(pqft_pkg::MODE_POP, 4'd0, '0);
   endtask

   // Full queue, bad priority on a full queue, limit dropped below held
   // priorities, limit zero and limit above sixteen.
   task automatic test_full_and_limits();
      int i;
      i = 0;
      while (held_value.size() < pqft_pkg::CAPACITY) begin
         issue_op(pqft_pkg::MODE_PUSH, PB'(i % 3 + 1), 32'h1111_1111 * (i + 1));
         i++;
         drain_results();
      end
      issue_op(pqft_pkg::MODE_PUSH, 4'd2, 32'h0bad_f00d);
      set_priority_limit(5'd8);
      issue_op(pqft_pkg::MODE_PUSH, 4'd12, 32'h1234_5678);
      issue_op(pqft_pkg::MODE_PUSH, 4'd7, 32'h8765_4321);
      repeat (3) issue_op(pqft_pkg::MODE_POP, '0, '0);
      set_priority_limit(5'd0);
      issue_op(pqft_pkg::MODE_PUSH, 4'd0, 32'h5555_aaaa);
      set_priority_limit(5'd31);
      issue_op(pqft_pkg::MODE_PUSH, 4'd15, 32'haaaa_5555);
   endtask

   // Result side held off for a long stretch while requests keep coming;
   // the core must stall its input, then catch up without loss.
   task automatic test_output_backpressure();
      drain_results();
      rx_style = RX_ALWAYS;
      hold_start = 1'b1;
      repeat (24) random_op(12);
      drain_results();
   endtask

   // Phases of random traffic under different limits and receiver styles.
   task automatic test_random_traffic();
      logic [LB-1:0] plan[10];
      int fill_target;
      plan = '{5'd16, 5'd1, 5'd31, 5'd6, 5'd0, 5'd2, 5'd16, 5'd11, 5'd3, 5'd16};
      for (int phase = 0; phase < 11; phase++) begin
         set_priority_limit((phase < 10) ? plan[phase] : LB'($urandom_range(1, 16)));
         rx_style = rx_style_type'($urandom_range(0, 3));
         gapless = ($urandom_range(0, 3) == 0);
         fill_target = $urandom_range(0, 18);
         for (int n = 0; n < PHASE_OPS; n++) begin
            if ($urandom_range(0, 19) == 0) fill_target = $urandom_range(0, 18);
            random_op(fill_target);
            sender_pause();
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_extremes_and_ties();
      test_full_and_limits();
      test_output_backpressure();
      test_random_traffic();

      drain_results();
      if (pending_results.size() != 0) begin
         report_failure($sformatf("%0d expected results never arrived",
                                  pending_results.size()));
      end

      $display("covered %0d requests: %0d ok, %0d full, %0d empty pops, %0d bad priority",
               ops_sent, status_seen[pqft_pkg::STATUS_OK], status_seen[pqft_pkg::STATUS_FULL],
               status_seen[pqft_pkg::STATUS_EMPTY], status_seen[pqft_pkg::STATUS_BAD_PRIO]);
      $display("%0d limit writes incl. 0, 1, 16, 31; one %0d-cycle output stall; %0d errors",
               limit_writes, HOLD_OFF_CYCLES, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
